// ===== sv/rem_pkg.sv =====
// ----------------------------------------------------------------------------
// rem_pkg
// Shared types, constants and the quarter-wave sine table builder of the
// rectangular extrusion mesh generator.
// ----------------------------------------------------------------------------
package rem_pkg;

  localparam int MAX_SECTIONS = 4096;
  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_BITS   = 16;

  localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);
  localparam int IDX_W   = 14;
  localparam int QBITS   = ANGLE_BITS - 2;
  localparam int QSIZE   = 1 << QBITS;
  localparam int ADDR_W  = QBITS + 1;
  localparam int SV_W    = FRAC_BITS + 1;
  localparam int HW_W    = 30;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        width;
    logic [30:0]        height;
    logic [15:0]        angle;
    logic               final_section;
  } section_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [IDX_W-1:0]   corner_a;
    logic [IDX_W-1:0]   corner_b;
    logic [IDX_W-1:0]   corner_c;
    logic [IDX_W-1:0]   corner_d;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [HW_W-1:0]    hw;
    logic [30:0]        height;
    logic [ADDR_W-1:0]  sin_addr;
    logic               sin_neg;
    logic [ADDR_W-1:0]  cos_addr;
    logic               cos_neg;
    logic               face_en;
    logic               front_cap;
    logic               back_cap;
    logic [IDX_W-1:0]   i1;
  } job_t;

  typedef logic [SV_W-1:0] sine_tab_t [0:QSIZE];

  localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611A;

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [SV_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = mul_shr(Q62_HALF_PI, 64'(k), QBITS);
    x2 = mul_shr(x, x, 62);
    t  = Q62_ONE;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd702;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd600;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd506;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd420;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd342;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd272;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd210;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd156;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd110;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd72;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd42;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd20;
    t  = Q62_ONE - mul_shr(x2, t, 62) / 64'd6;
    t  = mul_shr(x, t, 62);
    t  = (t + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    return t[SV_W-1:0];
  endfunction

endpackage

// ===== sv/rem_front.sv =====
// ----------------------------------------------------------------------------
// rem_front
// Accepts sections, tracks the section count of the current curve, drops
// sections past the limit and classifies the rest into jobs for the back end.
// ----------------------------------------------------------------------------
module rem_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rem_pkg::section_t in_data,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output rem_pkg::job_t     q_job
);

  localparam int PH_TMP_W = 16 + rem_pkg::ANGLE_BITS;
  localparam int ASH_L = (rem_pkg::ANGLE_BITS >= 16) ? rem_pkg::ANGLE_BITS - 16 : 0;
  localparam int ASH_R = (rem_pkg::ANGLE_BITS < 16) ? 16 - rem_pkg::ANGLE_BITS : 0;

  logic [rem_pkg::CNT_W-1:0]      cnt_r;
  logic [rem_pkg::CNT_W-1:0]      cnt_nxt;
  logic                           accept;
  logic                           drop;
  logic [PH_TMP_W-1:0]            ph_tmp;
  logic [rem_pkg::ANGLE_BITS-1:0] phase;
  logic [1:0]                     quad_s;
  logic [1:0]                     quad_c;
  logic [rem_pkg::QBITS-1:0]      k;
  logic [rem_pkg::ADDR_W-1:0]     k_fwd;
  logic [rem_pkg::ADDR_W-1:0]     k_rev;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign drop   = cnt_r >= rem_pkg::CNT_W'(rem_pkg::MAX_SECTIONS);
  assign q_push = accept && !drop;

  always_comb begin
    ph_tmp = PH_TMP_W'(in_data.angle);
    phase  = rem_pkg::ANGLE_BITS'((ph_tmp << ASH_L) >> ASH_R);
    quad_s = phase[rem_pkg::ANGLE_BITS-1 -: 2];
    quad_c = quad_s + 2'd1;
    k      = phase[rem_pkg::QBITS-1:0];
    k_fwd  = {1'b0, k};
    k_rev  = rem_pkg::ADDR_W'(rem_pkg::QSIZE) - k_fwd;

    q_job.pos_x     = in_data.pos_x;
    q_job.pos_y     = in_data.pos_y;
    q_job.hw        = in_data.width[30:1];
    q_job.height    = in_data.height;
    q_job.sin_addr  = quad_s[0] ? k_rev : k_fwd;
    q_job.sin_neg   = quad_s[1];
    q_job.cos_addr  = quad_c[0] ? k_rev : k_fwd;
    q_job.cos_neg   = quad_c[1];
    q_job.face_en   = cnt_r != '0;
    q_job.front_cap = cnt_r == rem_pkg::CNT_W'(1);
    q_job.back_cap  = (cnt_r != '0) && in_data.final_section;
    q_job.i1        = rem_pkg::IDX_W'(32'(cnt_r) << 2);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.final_section) begin
        cnt_nxt = '0;
      end else if (!drop) begin
        cnt_nxt = cnt_r + rem_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/rem_queue.sv =====
// ----------------------------------------------------------------------------
// rem_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rem_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  rem_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_empty,
  output rem_pkg::job_t rd_job
);

  rem_pkg::job_t               slot_r [rem_pkg::QUEUE_DEPTH];
  logic [rem_pkg::QPTR_W-1:0]  wp_r;
  logic [rem_pkg::QPTR_W-1:0]  rp_r;
  logic [rem_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_wr;
  logic                        do_rd;

  assign q_full  = cnt_r == rem_pkg::QCNT_W'(rem_pkg::QUEUE_DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + rem_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + rem_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_r + rem_pkg::QCNT_W'(do_wr) - rem_pkg::QCNT_W'(do_rd);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !do_rd) |=> q_full)
    else $error("queue lost an entry while full");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> !q_empty)
    else $error("queue empty after a lone write");
  a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_empty && !wr_en) |=> q_empty)
    else $error("queue filled with no write");
`endif

endmodule

// ===== sv/rem_back.sv =====
// ----------------------------------------------------------------------------
// rem_back
// Executes jobs: sine table lookup, height products, saturating vertex sums,
// then steps through the vertex and face results into the output register.
// ----------------------------------------------------------------------------
module rem_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rem_pkg::job_t     q_job,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output rem_pkg::result_t  out_data
);

  localparam int PROD_W = 31 + rem_pkg::SV_W;
  localparam int NX_W   = 33;
  localparam int SUM_W  = 34;

  typedef enum logic [9:0] {
    STEP_V0     = 10'b0000000001,
    STEP_V1     = 10'b0000000010,
    STEP_V2     = 10'b0000000100,
    STEP_V3     = 10'b0000001000,
    STEP_FRONT  = 10'b0000010000,
    STEP_BACK   = 10'b0000100000,
    STEP_TOP    = 10'b0001000000,
    STEP_BOTTOM = 10'b0010000000,
    STEP_LEFT   = 10'b0100000000,
    STEP_RIGHT  = 10'b1000000000
  } step_t;

  rem_pkg::sine_tab_t sine_rom;

  initial begin
    for (int k = 0; k <= rem_pkg::QSIZE; k++) begin
      sine_rom[k] = rem_pkg::quarter_sine(k);
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic                        adv;
  logic                        s1_valid_r;
  logic                        s2_valid_r;
  logic                        s3_valid_r;
  rem_pkg::job_t               s1_job_r;
  rem_pkg::job_t               s2_job_r;
  rem_pkg::job_t               s3_job_r;
  logic [rem_pkg::SV_W-1:0]    sin_v_r;
  logic [rem_pkg::SV_W-1:0]    cos_v_r;
  logic [PROD_W-1:0]           psin_r;
  logic [PROD_W-1:0]           pcos_r;
  logic signed [PROD_W:0]      nx_full;
  logic signed [PROD_W:0]      ny_full;
  logic signed [PROD_W:0]      nx_shr;
  logic signed [PROD_W:0]      ny_shr;
  logic signed [SUM_W-1:0]     sum_x;
  logic signed [SUM_W-1:0]     sum_y;
  logic signed [31:0]          qx_r;
  logic signed [31:0]          qy_r;

  logic                        gen_valid_r;
  logic                        gen_valid_nxt;
  step_t                       gen_step_r;
  step_t                       gen_step_nxt;
  step_t                       step_after;
  rem_pkg::job_t               gen_job_r;
  logic signed [31:0]          gen_qx_r;
  logic signed [31:0]          gen_qy_r;
  logic                        gen_load;
  logic                        emit;
  logic                        last;
  logic                        out_valid_r;
  rem_pkg::result_t            out_r;
  rem_pkg::result_t            res;
  logic [rem_pkg::IDX_W-1:0]   i0;
  logic [rem_pkg::IDX_W-1:0]   i1;
  logic signed [31:0]          hw_s;

  assign emit     = gen_valid_r && (!out_valid_r || pop);
  assign gen_load = s3_valid_r && (!gen_valid_r || (emit && last));
  assign adv      = !s3_valid_r || gen_load;
  assign q_pop    = adv && !q_empty;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  // lookup, multiply and sum stages
  always_ff @(posedge clk) begin
    if (adv) begin
      sin_v_r  <= sine_rom[q_job.sin_addr];
      cos_v_r  <= sine_rom[q_job.cos_addr];
      s1_job_r <= q_job;
      psin_r   <= PROD_W'(s1_job_r.height) * PROD_W'(sin_v_r);
      pcos_r   <= PROD_W'(s1_job_r.height) * PROD_W'(cos_v_r);
      s2_job_r <= s1_job_r;
      qx_r     <= sat32(sum_x);
      qy_r     <= sat32(sum_y);
      s3_job_r <= s2_job_r;
    end
  end

  always_comb begin
    nx_full = s2_job_r.sin_neg ? signed'({1'b0, psin_r}) : -signed'({1'b0, psin_r});
    ny_full = s2_job_r.cos_neg ? -signed'({1'b0, pcos_r}) : signed'({1'b0, pcos_r});
    nx_shr  = nx_full >>> rem_pkg::FRAC_BITS;
    ny_shr  = ny_full >>> rem_pkg::FRAC_BITS;
    sum_x   = SUM_W'(s2_job_r.pos_x) + SUM_W'(signed'(nx_shr[NX_W-1:0]));
    sum_y   = SUM_W'(s2_job_r.pos_y) + SUM_W'(signed'(ny_shr[NX_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= !q_empty;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // result sequencer
  always_comb begin
    step_after = STEP_V0;
    last       = 1'b0;
    unique case (gen_step_r)
      STEP_V0: step_after = STEP_V1;
      STEP_V1: step_after = STEP_V2;
      STEP_V2: step_after = STEP_V3;
      STEP_V3: begin
        if (!gen_job_r.face_en) begin
          last = 1'b1;
        end else if (gen_job_r.front_cap) begin
          step_after = STEP_FRONT;
        end else if (gen_job_r.back_cap) begin
          step_after = STEP_BACK;
        end else begin
          step_after = STEP_TOP;
        end
      end
      STEP_FRONT: step_after = gen_job_r.back_cap ? STEP_BACK : STEP_TOP;
      STEP_BACK: step_after = STEP_TOP;
      STEP_TOP: step_after = STEP_BOTTOM;
      STEP_BOTTOM: step_after = STEP_LEFT;
      STEP_LEFT: step_after = STEP_RIGHT;
      STEP_RIGHT: last = 1'b1;
      default: step_after = STEP_V0;
    endcase
  end

  always_comb begin
    gen_valid_nxt = gen_valid_r;
    gen_step_nxt  = gen_step_r;
    if (gen_load) begin
      gen_valid_nxt = 1'b1;
      gen_step_nxt  = STEP_V0;
    end else if (emit) begin
      gen_valid_nxt = !last;
      gen_step_nxt  = step_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_valid_r <= 1'b0;
      gen_step_r  <= STEP_V0;
    end else begin
      gen_valid_r <= gen_valid_nxt;
      gen_step_r  <= gen_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_load) begin
      gen_job_r <= s3_job_r;
      gen_qx_r  <= qx_r;
      gen_qy_r  <= qy_r;
    end
  end

  always_comb begin
    i1   = gen_job_r.i1;
    i0   = i1 - rem_pkg::IDX_W'(4);
    hw_s = {2'b00, gen_job_r.hw};
    res  = '0;
    res.last_of_run = last;
    unique case (gen_step_r)
      STEP_V0: begin
        res.kind    = rem_pkg::KIND_VERTEX;
        res.coord_x = gen_job_r.pos_x;
        res.coord_y = gen_job_r.pos_y;
        res.coord_z = hw_s;
      end
      STEP_V1: begin
        res.kind    = rem_pkg::KIND_VERTEX;
        res.coord_x = gen_qx_r;
        res.coord_y = gen_qy_r;
        res.coord_z = hw_s;
      end
      STEP_V2: begin
        res.kind    = rem_pkg::KIND_VERTEX;
        res.coord_x = gen_qx_r;
        res.coord_y = gen_qy_r;
        res.coord_z = -hw_s;
      end
      STEP_V3: begin
        res.kind    = rem_pkg::KIND_VERTEX;
        res.coord_x = gen_job_r.pos_x;
        res.coord_y = gen_job_r.pos_y;
        res.coord_z = -hw_s;
      end
      STEP_FRONT: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i0;
        res.corner_b = i0 + rem_pkg::IDX_W'(1);
        res.corner_c = i0 + rem_pkg::IDX_W'(2);
        res.corner_d = i0 + rem_pkg::IDX_W'(3);
      end
      STEP_BACK: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i1;
        res.corner_b = i1 + rem_pkg::IDX_W'(3);
        res.corner_c = i1 + rem_pkg::IDX_W'(2);
        res.corner_d = i1 + rem_pkg::IDX_W'(1);
      end
      STEP_TOP: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i0;
        res.corner_b = i0 + rem_pkg::IDX_W'(3);
        res.corner_c = i1 + rem_pkg::IDX_W'(3);
        res.corner_d = i1;
      end
      STEP_BOTTOM: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i0 + rem_pkg::IDX_W'(1);
        res.corner_b = i1 + rem_pkg::IDX_W'(1);
        res.corner_c = i1 + rem_pkg::IDX_W'(2);
        res.corner_d = i0 + rem_pkg::IDX_W'(2);
      end
      STEP_LEFT: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i0;
        res.corner_b = i1;
        res.corner_c = i1 + rem_pkg::IDX_W'(1);
        res.corner_d = i0 + rem_pkg::IDX_W'(1);
      end
      STEP_RIGHT: begin
        res.kind     = rem_pkg::KIND_FACE;
        res.corner_a = i0 + rem_pkg::IDX_W'(2);
        res.corner_b = i1 + rem_pkg::IDX_W'(2);
        res.corner_c = i1 + rem_pkg::IDX_W'(3);
        res.corner_d = i0 + rem_pkg::IDX_W'(3);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_valid_r && !emit) |=> (gen_valid_r && $stable(gen_step_r)))
    else $error("sequencer moved without emitting");
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !adv) |=> s3_valid_r)
    else $error("stalled job dropped from pipeline");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted result not presented");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    gen_load |-> (!gen_valid_r || last))
    else $error("sequencer reloaded mid run");
`endif

endmodule

// ===== sv/rectangular_extrusion_mesh_gen.sv =====
// ----------------------------------------------------------------------------
// rectangular_extrusion_mesh_gen
// Turns curve sections into cross-section vertices and joining quad faces.
// ----------------------------------------------------------------------------
// Each accepted section yields four vertices, and from the second section of a
// curve on, the faces joining it to the previous one (four, plus a front cap on
// the first segment and a back cap on a final section). Results leave one per
// cycle, while the output is popped, through a single output register: a
// section has 4 results if it is the first, 8 to 10 otherwise, set by the result
// sequencer. A four-entry job queue separates the input side from a three-stage
// lookup, multiply and sum pipeline, so sections keep arriving while earlier
// results are still draining. The quarter-wave sine table is a read-only memory
// whose contents are computed when the design is loaded and needs no clearing
// pass. Sections beyond the limit are dropped with no result, a dropped final
// section still ends the curve.
module rectangular_extrusion_mesh_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rem_pkg::section_t in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output rem_pkg::result_t  out_data
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  rem_pkg::job_t q_wr_job;
  rem_pkg::job_t q_rd_job;

  rem_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_push),
    .q_job   (q_wr_job)
  );

  rem_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (q_wr_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_job  (q_rd_job)
  );

  rem_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_rd_job),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== verif/mesh_check_pkg.sv =====
// ----------------------------------------------------------------------------
// mesh_check_pkg
// Expected-mesh scoreboard for the rectangular extrusion mesh generator:
// predicts the vertices and joining faces of every accepted section and
// compares the block's results against them in order.
// ----------------------------------------------------------------------------
package mesh_check_pkg;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  class mesh_scoreboard;

    rem_pkg::result_t    expected_mesh[$];
    longint unsigned     wave_cache[int unsigned];
    int unsigned         section_count;
    int                  sections_seen;
    int                  sections_dropped;
    int                  results_checked;
    int                  mismatches;

    function new();
      section_count    = 0;
      sections_seen    = 0;
      sections_dropped = 0;
      results_checked  = 0;
      mismatches       = 0;
    endfunction

    function int pending();
      return expected_mesh.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b, int unsigned sh);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      wide = wide >> sh;
      return wide[63:0];
    endfunction

    // sine of k/QSIZE of a quarter turn, FRAC_BITS fraction bits, rounded
    function longint unsigned quarter_wave(int unsigned k);
      logic [63:0] ang;
      logic [63:0] sq;
      logic [63:0] acc;
      if (wave_cache.exists(k)) begin
        return wave_cache[k];
      end
      ang = mul_q62(HALF_PI_Q62, 64'(k), rem_pkg::QBITS);
      sq  = mul_q62(ang, ang, 62);
      acc = ONE_Q62;
      for (int n = 13; n >= 1; n--) begin
        acc = ONE_Q62 - mul_q62(sq, acc, 62) / 64'((2 * n) * (2 * n + 1));
      end
      acc = mul_q62(ang, acc, 62);
      acc = (acc + (64'd1 << (61 - rem_pkg::FRAC_BITS))) >> (62 - rem_pkg::FRAC_BITS);
      wave_cache[k] = acc;
      return acc;
    endfunction

    function longint sine_at(int unsigned phase);
      int unsigned quad;
      int unsigned k;
      longint      v;
      quad = (phase >> rem_pkg::QBITS) & 3;
      k    = phase & (rem_pkg::QSIZE - 1);
      v    = (quad & 1) ? longint'(quarter_wave(rem_pkg::QSIZE - k))
                        : longint'(quarter_wave(k));
      return (quad & 2) ? -v : v;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        return 32'sh8000_0000;
      end
      return 32'(v);
    endfunction

    function void add_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      rem_pkg::result_t r;
      r         = '0;
      r.kind    = rem_pkg::KIND_VERTEX;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      expected_mesh.push_back(r);
    endfunction

    function void add_face(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
      rem_pkg::result_t r;
      r          = '0;
      r.kind     = rem_pkg::KIND_FACE;
      r.corner_a = rem_pkg::IDX_W'(a);
      r.corner_b = rem_pkg::IDX_W'(b);
      r.corner_c = rem_pkg::IDX_W'(c);
      r.corner_d = rem_pkg::IDX_W'(d);
      expected_mesh.push_back(r);
    endfunction

    function void note_section(rem_pkg::section_t s);
      int unsigned        phase;
      int unsigned        full_turn;
      int unsigned        n;
      longint             h;
      longint             nx;
      longint             ny;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] zp;
      int unsigned        i0;
      int unsigned        i1;
      sections_seen++;
      if (section_count >= rem_pkg::MAX_SECTIONS) begin
        sections_dropped++;
        if (s.final_section) begin
          section_count = 0;
        end
        return;
      end
      full_turn = 1 << rem_pkg::ANGLE_BITS;
      phase = 32'(s.angle);
      if (rem_pkg::ANGLE_BITS >= 16) begin
        phase = phase << (rem_pkg::ANGLE_BITS - 16);
      end else begin
        phase = phase >> (16 - rem_pkg::ANGLE_BITS);
      end
      phase = phase & (full_turn - 1);
      px = s.pos_x;
      py = s.pos_y;
      h  = longint'(s.height);
      nx = (-(h * sine_at(phase))) >>> rem_pkg::FRAC_BITS;
      ny = (h * sine_at((phase + rem_pkg::QSIZE) & (full_turn - 1))) >>> rem_pkg::FRAC_BITS;
      qx = clamp32(longint'(px) + nx);
      qy = clamp32(longint'(py) + ny);
      zp = {2'b00, s.width[30:1]};
      add_vertex(px, py, zp);
      add_vertex(qx, qy, zp);
      add_vertex(qx, qy, -zp);
      add_vertex(px, py, -zp);
      n = section_count;
      if (n >= 1) begin
        i0 = 4 * (n - 1);
        i1 = 4 * n;
        if (n == 1) begin
          add_face(i0, i0 + 1, i0 + 2, i0 + 3);
        end
        if (s.final_section) begin
          add_face(i1, i1 + 3, i1 + 2, i1 + 1);
        end
        add_face(i0, i0 + 3, i1 + 3, i1);
        add_face(i0 + 1, i1 + 1, i1 + 2, i0 + 2);
        add_face(i0, i1, i1 + 1, i0 + 1);
        add_face(i0 + 2, i1 + 2, i1 + 3, i0 + 3);
      end
      expected_mesh[expected_mesh.size() - 1].last_of_run = 1'b1;
      section_count = s.final_section ? 0 : section_count + 1;
    endfunction

    task check_result(rem_pkg::result_t got);
      rem_pkg::result_t want;
      string            bad;
      if (expected_mesh.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_mesh.pop_front();
      bad  = "";
      if (got.kind !== want.kind)               bad = {bad, " kind"};
      if (got.coord_x !== want.coord_x)         bad = {bad, " coord_x"};
      if (got.coord_y !== want.coord_y)         bad = {bad, " coord_y"};
      if (got.coord_z !== want.coord_z)         bad = {bad, " coord_z"};
      if (got.corner_a !== want.corner_a)       bad = {bad, " corner_a"};
      if (got.corner_b !== want.corner_b)       bad = {bad, " corner_b"};
      if (got.corner_c !== want.corner_c)       bad = {bad, " corner_c"};
      if (got.corner_d !== want.corner_d)       bad = {bad, " corner_d"};
      if (got.last_of_run !== want.last_of_run) bad = {bad, " last_of_run"};
      if (bad != "") begin
        report($sformatf("result %0d differs in%s: got %h want %h",
                         results_checked, bad, got, want));
      end
      results_checked++;
    endtask

  endclass

endpackage

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the rectangular extrusion mesh generator: directed sections at
// the field extremes, then random curves with bursty idling on both sides and
// a long output hold-off, every result checked against a scoreboard
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 200;
  localparam int STEADY_ITEMS   = 40;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;

  logic              clk;
  logic              rst_n;
  logic              push;
  rem_pkg::section_t in_data;
  logic              full;
  logic              empty;
  logic              pop;
  rem_pkg::result_t  out_data;

  mesh_check_pkg::mesh_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  bit hold_done;
  int full_stalls;
  int stall_cycles;

  rectangular_extrusion_mesh_gen uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rem_pkg::section_t make_section(int x, int y, int unsigned w,
                                                     int unsigned h, int unsigned ang,
                                                     bit fin);
    rem_pkg::section_t s;
    s.pos_x         = x;
    s.pos_y         = y;
    s.width         = 31'(w);
    s.height        = 31'(h);
    s.angle         = 16'(ang);
    s.final_section = fin;
    return s;
  endfunction

  function automatic rem_pkg::section_t rand_section(bit fin);
    rem_pkg::section_t s;
    int unsigned special_angles[9] = '{0, 1, 16383, 16384, 16385, 32767, 32768, 49152, 65535};
    s.pos_x = $urandom;
    s.pos_y = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      s.pos_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1 << 20)
                                      : 32'h8000_0000 + $urandom_range(0, 1 << 20);
      s.pos_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1 << 20)
                                      : 32'h8000_0000 + $urandom_range(0, 1 << 20);
    end
    case ($urandom_range(0, 3))
      0: s.width = 31'($urandom_range(0, 1 << 20));
      1: s.width = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: s.width = 31'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: s.height = 31'($urandom_range(0, 1 << 20));
      1: s.height = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: s.height = 31'($urandom);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      s.angle = 16'(special_angles[$urandom_range(0, 8)]);
    end else begin
      s.angle = 16'($urandom);
    end
    s.final_section = fin;
    return s;
  endfunction

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    push    = 1'b0;
    in_data = rand_section(1'($urandom_range(0, 1)));
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic offer_section(input rem_pkg::section_t s);
    if (!hold_request && tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      idle_gap($urandom_range(1, 19));
    end
    @(negedge clk);
    push    = 1'b1;
    in_data = s;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    sb.note_section(s);
  endtask

  task automatic offer_random_curve(input int len);
    for (int i = 0; i < len; i++) begin
      offer_section(rand_section(i == len - 1));
    end
  endtask

  // result side: bursty pop, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("timeout: no request moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int sent;
    int len;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    tx_idle_pct  = 20;
    rx_idle_pct  = 15;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    full_stalls  = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // lone final section: vertices only
    offer_section(make_section(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                               31'h7FFF_FFFF, 0, 1'b1));
    // single segment: front and back caps, saturation on both axes
    offer_section(make_section(32'h7FFF_FFF0, 32'h8000_0010, 31'h7FFF_FFFF,
                               31'h7FFF_FFFF, 49152, 1'b0));
    offer_section(make_section(32'h8000_0000, 32'h8000_0000, 1, 31'h7FFF_FFFF,
                               32768, 1'b1));
    // four-section curve through the quadrant boundaries
    offer_section(make_section(0, 0, 0, 0, 0, 1'b0));
    offer_section(make_section(32'h0001_0000, -32'sh0001_0000, 2, 1, 16384, 1'b0));
    offer_section(make_section(-1, -1, 3, 32'h0001_0000, 65535, 1'b0));
    offer_section(make_section(32'h1234_5678, 32'h7FFF_FFFF, 31'h4000_0000,
                               31'h7FFF_FFFF, 8192, 1'b1));
    offer_section(make_section(32'h0FFF_0000, 32'h8000_0000, 31'h5555_5555,
                               31'h2AAA_AAAA, 1, 1'b0));
    offer_section(make_section(-32'sh0100_0000, 32'h0100_0000, 31'h2AAA_AAAA,
                               31'h5555_5555, 16383, 1'b0));
    offer_section(make_section(32'h7FFF_0000, 32'h0000_FFFF, 31'h7FFF_FFFE,
                               31'h7FFF_FFFF, 16385, 1'b1));
    offer_section(make_section(32'h8000_0001, 32'h7FFF_FFFE, 5, 31'h7FFF_FFFF,
                               32767, 1'b0));
    offer_section(make_section(32'h8000_0000, 32'h7FFF_FFFF, 7, 31'h7FFF_FFFF,
                               49151, 1'b0));
    offer_section(make_section(32'h7FFF_FFFF, 32'h8000_0000, 9, 31'h7FFF_FFFF,
                               49153, 1'b1));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - STEADY_ITEMS) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(0, 2) * 15;
        rx_idle_pct = $urandom_range(0, 2) * 10;
      end
      if (!hold_done && sent >= 60) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      case ($urandom_range(0, 5))
        0: len = 1;
        1: len = 2;
        default: len = $urandom_range(3, 8);
      endcase
      offer_random_curve(len);
      sent += len;
    end
    @(negedge clk);
    push = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sections (%0d dropped past the limit), %0d results checked",
             sb.sections_seen, sb.sections_dropped, sb.results_checked);
    $display("input held off by full for %0d cycles, including a %0d-cycle output hold",
             full_stalls, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
